@@ rtl/core/rmcd_pkg.sv @@
package rmcd_pkg;

  localparam int unsigned CfgSmallW = 4;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MARKER_COUNT_THRESHOLD = 3'd0,
    REG_MARKER_RUN_WIDTH       = 3'd1,
    REG_CLEAR_MAX_ACTIVE       = 3'd2,
    REG_CLEAR_CONFIRM_TIME     = 3'd3,
    REG_MARKER_MIN_ELAPSED     = 3'd4,
    REG_MARKER_CONFIRM_TIME    = 3'd5,
    REG_RUN_START_TIME         = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgSmallW-1:0] count_thr;
    logic [CfgSmallW-1:0] run_width;
    logic [CfgSmallW-1:0] clear_max;
  } scan_cfg_t;

  typedef struct packed {
    logic present;
    logic eligible;
  } scan_res_t;

endpackage

@@ rtl/core/rmcd_scan.sv @@
module rmcd_scan
  import rmcd_pkg::*;
#(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  logic [SENSOR_COUNT-1:0] mask_i,
  input  scan_cfg_t               cfg_i,
  output scan_res_t               res_o
);

  localparam int unsigned CntW   = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned CmpW   = (CntW > CfgSmallW) ? CntW : CfgSmallW;
  localparam int unsigned RunMax = (1 << CfgSmallW) - 1;

  logic [SENSOR_COUNT-1:0] win [RunMax];
  logic [RunMax-1:0]       hit;
  logic [CntW-1:0]         cnt;
  logic [CmpW-1:0]         cnt_ext;
  logic                    run_ok;
  logic [CfgSmallW-1:0]    run_idx;

  // window k holds bits that start a run of k+1 active sensors
  assign win[0] = mask_i;
  for (genvar k = 1; k < RunMax; k++) begin : g_win
    assign win[k] = win[k-1] & (win[k-1] >> 1);
  end
  for (genvar k = 0; k < RunMax; k++) begin : g_hit
    assign hit[k] = |win[k];
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      cnt = cnt + CntW'(mask_i[i]);
    end
  end

  assign cnt_ext = CmpW'(cnt);
  assign run_idx = cfg_i.run_width - CfgSmallW'(1);
  assign run_ok  = (cfg_i.run_width == '0) || hit[run_idx];

  assign res_o.present  = (cnt_ext >= CmpW'(cfg_i.count_thr)) && run_ok;
  assign res_o.eligible = (cnt != '0) && (cnt_ext <= CmpW'(cfg_i.clear_max))
                          && !res_o.present;

endmodule

@@ rtl/core/route_marker_confirm_detector_top.sv @@
// channel  | valid         | stall         | payload
// ---------+---------------+---------------+------------------------------------------
// input    | in_valid_i    | in_stall_o    | sensor_mask_i, sample_time_i
// output   | out_valid_o   | out_stall_i   | out_time_o, marker_seen_o, start_done_o,
//          |               |               | start_done_pulse_o, go_straight_o,
//          |               |               | marker_done_o, marker_done_pulse_o
// config   | cfg_we_i      | -             | cfg_idx_i, cfg_data_i
//
// one transaction per cycle while the output is not stalled; an accepted input passes through
// the input register, then scan and timer compares into the result register
// reset clears all detector state and loads the register defaults
// output stall holds the result register and backs up into the input register;
// in_stall_o rises only when both registers are full and the output is stalled
module route_marker_confirm_detector_top
  import rmcd_pkg::*;
#(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SENSOR_COUNT-1:0] sensor_mask_i,
  input  logic [TimeW-1:0]        sample_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TimeW-1:0]        out_time_o,
  output logic                    marker_seen_o,
  output logic                    start_done_o,
  output logic                    start_done_pulse_o,
  output logic                    go_straight_o,
  output logic                    marker_done_o,
  output logic                    marker_done_pulse_o
);

  scan_cfg_t       scfg_q;
  logic [TimeW-1:0] clear_time_q, min_elapsed_q, marker_time_q, run_start_q;

  logic                    s1_valid_q;
  logic [SENSOR_COUNT-1:0] s1_mask_q;
  logic [TimeW-1:0]        s1_time_q;
  logic                    s1_adv, s1_fire;

  logic             cleared_q, cleared_d;
  logic             clr_pend_q, clr_pend_d;
  logic [TimeW-1:0] clr_since_q, clr_since_d;
  logic             conf_q, conf_d;
  logic             mk_pend_q, mk_pend_d;
  logic [TimeW-1:0] mk_since_q, mk_since_d;
  logic             clr_evt, conf_evt;
  logic [TimeW-1:0] elapsed;

  scan_res_t scan;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scfg_q.count_thr <= CfgSmallW'(3);
      scfg_q.run_width <= '0;
      scfg_q.clear_max <= CfgSmallW'(2);
      clear_time_q     <= '0;
      min_elapsed_q    <= '0;
      marker_time_q    <= '0;
      run_start_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MARKER_COUNT_THRESHOLD: scfg_q.count_thr <= cfg_data_i[CfgSmallW-1:0];
        REG_MARKER_RUN_WIDTH:       scfg_q.run_width <= cfg_data_i[CfgSmallW-1:0];
        REG_CLEAR_MAX_ACTIVE:       scfg_q.clear_max <= cfg_data_i[CfgSmallW-1:0];
        REG_CLEAR_CONFIRM_TIME:     clear_time_q     <= cfg_data_i[TimeW-1:0];
        REG_MARKER_MIN_ELAPSED:     min_elapsed_q    <= cfg_data_i[TimeW-1:0];
        REG_MARKER_CONFIRM_TIME:    marker_time_q    <= cfg_data_i[TimeW-1:0];
        REG_RUN_START_TIME:         run_start_q      <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_mask_q <= sensor_mask_i;
      s1_time_q <= sample_time_i;
    end
  end

  rmcd_scan #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_scan (
    .mask_i(s1_mask_q),
    .cfg_i (scfg_q),
    .res_o (scan)
  );

  // start clear
  always_comb begin
    cleared_d   = cleared_q;
    clr_pend_d  = clr_pend_q;
    clr_since_d = clr_since_q;
    clr_evt     = 1'b0;
    if (!cleared_q) begin
      priority if (!scan.eligible) begin
        clr_pend_d = 1'b0;
      end else if (!clr_pend_q) begin
        clr_pend_d  = 1'b1;
        clr_since_d = s1_time_q;
      end else begin
        if ((s1_time_q - clr_since_q) >= clear_time_q) begin
          cleared_d  = 1'b1;
          clr_pend_d = 1'b0;
          clr_evt    = 1'b1;
        end
      end
    end
  end

  // marker confirm, sees this sample's start clear
  assign elapsed = s1_time_q - run_start_q;

  always_comb begin
    conf_d     = conf_q;
    mk_pend_d  = mk_pend_q;
    mk_since_d = mk_since_q;
    conf_evt   = 1'b0;
    if (!conf_q) begin
      priority if (!scan.present || !cleared_d || (elapsed < min_elapsed_q)) begin
        mk_pend_d = 1'b0;
      end else if (marker_time_q == '0) begin
        conf_d   = 1'b1;
        conf_evt = 1'b1;
      end else if (!mk_pend_q) begin
        mk_pend_d  = 1'b1;
        mk_since_d = s1_time_q;
      end else begin
        if ((s1_time_q - mk_since_q) >= marker_time_q) begin
          conf_d    = 1'b1;
          mk_pend_d = 1'b0;
          conf_evt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cleared_q   <= 1'b0;
      clr_pend_q  <= 1'b0;
      clr_since_q <= '0;
      conf_q      <= 1'b0;
      mk_pend_q   <= 1'b0;
      mk_since_q  <= '0;
    end else if (s1_fire) begin
      cleared_q   <= cleared_d;
      clr_pend_q  <= clr_pend_d;
      clr_since_q <= clr_since_d;
      conf_q      <= conf_d;
      mk_pend_q   <= mk_pend_d;
      mk_since_q  <= mk_since_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_time_o          <= s1_time_q;
      marker_seen_o       <= scan.present;
      start_done_o        <= cleared_d;
      start_done_pulse_o  <= clr_evt;
      go_straight_o       <= scan.present && !cleared_d;
      marker_done_o       <= conf_d;
      marker_done_pulse_o <= conf_evt;
    end
  end

`ifndef ASSERT_OFF
  a_conf_needs_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conf_q |-> cleared_q)
    else $error("marker confirmed without start clear");

  a_clear_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cleared_q |=> cleared_q)
    else $error("start clear flag dropped");

  a_pulse_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && marker_done_pulse_o |-> marker_done_o && start_done_o)
    else $error("marker pulse without latched flags");

  a_go_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && go_straight_o |-> marker_seen_o && !start_done_o)
    else $error("go straight inconsistent with marker and start state");
`endif

endmodule

@@ tb/tb_route_marker_confirm_detector_top.sv @@
module tb_route_marker_confirm_detector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmcd_pkg::*;

  localparam int SENSOR_COUNT = 8;

  typedef struct {
    logic [SENSOR_COUNT-1:0] mask;
    logic [TimeW-1:0]        stamp;
  } snapshot_t;

  typedef struct {
    logic [TimeW-1:0] stamp;
    logic             seen;
    logic             cleared;
    logic             cleared_pulse;
    logic             straight;
    logic             confirmed;
    logic             confirmed_pulse;
  } verdict_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [SENSOR_COUNT-1:0] sensor_mask_i = '0;
  logic [TimeW-1:0]        sample_time_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [TimeW-1:0]        out_time_o;
  logic                    marker_seen_o;
  logic                    start_done_o;
  logic                    start_done_pulse_o;
  logic                    go_straight_o;
  logic                    marker_done_o;
  logic                    marker_done_pulse_o;

  route_marker_confirm_detector_top #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sensor_mask_i      (sensor_mask_i),
    .sample_time_i      (sample_time_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_time_o         (out_time_o),
    .marker_seen_o      (marker_seen_o),
    .start_done_o       (start_done_o),
    .start_done_pulse_o (start_done_pulse_o),
    .go_straight_o      (go_straight_o),
    .marker_done_o      (marker_done_o),
    .marker_done_pulse_o(marker_done_pulse_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // detector settings as last written
  logic [CfgSmallW-1:0] thr_cfg = 4'd3;
  logic [CfgSmallW-1:0] run_cfg = 4'd0;
  logic [CfgSmallW-1:0] clr_max_cfg = 4'd2;
  logic [TimeW-1:0]     clr_hold_cfg = '0;
  logic [TimeW-1:0]     min_elapsed_cfg = '0;
  logic [TimeW-1:0]     mk_hold_cfg = '0;
  logic [TimeW-1:0]     run_start_cfg = '0;

  // detector state
  logic             clear_latched = 1'b0;
  logic             clear_armed = 1'b0;
  logic [TimeW-1:0] clear_since = '0;
  logic             mk_latched = 1'b0;
  logic             mk_armed = 1'b0;
  logic [TimeW-1:0] mk_since = '0;

  snapshot_t  snapshot_q[$];
  verdict_t   verdict_q[$];
  snapshot_t  cur_snap;
  verdict_t   want;
  int         fail_count = 0;
  int         taken_count = 0;
  int         tx_gap = 0;
  int         tx_calm = 0;
  int         rx_wait = 0;
  int         rx_calm = 0;
  int         rx_hold = 0;
  logic       in_fire_q = 1'b0;
  logic       out_fire_q = 1'b0;
  logic [TimeW-1:0] now_ms = '0;

  function automatic verdict_t detect_step(logic [SENSOR_COUNT-1:0] mask, logic [TimeW-1:0] now);
    verdict_t r;
    int i, cnt, streak, longest;
    logic present, eligible;
    logic [TimeW-1:0] gap_ms;
    cnt = 0;
    streak = 0;
    longest = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (mask[i]) begin
        cnt++;
        streak++;
        if (streak > longest) longest = streak;
      end else begin
        streak = 0;
      end
    end
    present = (cnt >= int'(thr_cfg)) && (run_cfg == '0 || longest >= int'(run_cfg));
    eligible = (cnt > 0) && (cnt <= int'(clr_max_cfg)) && !present;
    r.cleared_pulse = 1'b0;
    r.confirmed_pulse = 1'b0;

    if (!clear_latched) begin
      gap_ms = now - clear_since;
      if (!eligible) begin
        clear_armed = 1'b0;
      end else if (!clear_armed) begin
        clear_armed = 1'b1;
        clear_since = now;
      end else if (gap_ms >= clr_hold_cfg) begin
        clear_latched = 1'b1;
        clear_armed = 1'b0;
        r.cleared_pulse = 1'b1;
      end
    end

    if (!mk_latched) begin
      gap_ms = now - run_start_cfg;
      if (!present || !clear_latched || gap_ms < min_elapsed_cfg) begin
        mk_armed = 1'b0;
      end else if (mk_hold_cfg == '0) begin
        mk_latched = 1'b1;
        r.confirmed_pulse = 1'b1;
      end else if (!mk_armed) begin
        mk_armed = 1'b1;
        mk_since = now;
      end else begin
        gap_ms = now - mk_since;
        if (gap_ms >= mk_hold_cfg) begin
          mk_latched = 1'b1;
          mk_armed = 1'b0;
          r.confirmed_pulse = 1'b1;
        end
      end
    end

    r.stamp = now;
    r.seen = present;
    r.cleared = clear_latched;
    r.straight = present && !clear_latched;
    r.confirmed = mk_latched;
    return r;
  endfunction

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 6);
  endfunction

  task automatic check_field(string name, logic [TimeW-1:0] exp_v, logic [TimeW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // input side: one snapshot transaction at a time, random gaps between them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire_q) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (snapshot_q.size() > 0) begin
          cur_snap = snapshot_q.pop_front();
          in_valid_i <= 1'b1;
          sensor_mask_i <= cur_snap.mask;
          sample_time_i <= cur_snap.stamp;
          tx_gap = pick_wait(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls plus a long hold-off now and then
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire_q) begin
        rx_wait = pick_wait(rx_calm);
        if (taken_count % 200 == 150) rx_hold = 60;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(detect_step(sensor_mask_i, sample_time_i));
      end
      if (out_valid_o && !out_stall_i) begin
        taken_count++;
        if (verdict_q.size() == 0) begin
          $error("result transaction with none expected, out_time %0h", out_time_o);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("out_time", want.stamp, out_time_o);
          check_field("marker_seen", want.seen, marker_seen_o);
          check_field("start_done", want.cleared, start_done_o);
          check_field("start_done_pulse", want.cleared_pulse, start_done_pulse_o);
          check_field("go_straight", want.straight, go_straight_o);
          check_field("marker_done", want.confirmed, marker_done_o);
          check_field("marker_done_pulse", want.confirmed_pulse, marker_done_pulse_o);
        end
      end
    end
    in_fire_q <= in_valid_i && !in_stall_o;
    out_fire_q <= out_valid_o && !out_stall_i;
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_MARKER_COUNT_THRESHOLD: thr_cfg = val[CfgSmallW-1:0];
      REG_MARKER_RUN_WIDTH:       run_cfg = val[CfgSmallW-1:0];
      REG_CLEAR_MAX_ACTIVE:       clr_max_cfg = val[CfgSmallW-1:0];
      REG_CLEAR_CONFIRM_TIME:     clr_hold_cfg = val;
      REG_MARKER_MIN_ELAPSED:     min_elapsed_cfg = val;
      REG_MARKER_CONFIRM_TIME:    mk_hold_cfg = val;
      REG_RUN_START_TIME:         run_start_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_snap(logic [SENSOR_COUNT-1:0] mask, logic [TimeW-1:0] stamp);
    snapshot_t s;
    s.mask = mask;
    s.stamp = stamp;
    snapshot_q.push_back(s);
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (snapshot_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // streaks of one mask kind so candidates and markers persist across samples
  task automatic run_stream(int n, bit jumps);
    int k, j, kind, len, width, pos;
    logic [SENSOR_COUNT-1:0] m;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 8);
      for (j = 0; j < len && k < n; j++) begin
        case (kind)
          0, 1, 2, 3: begin
            m = SENSOR_COUNT'(1 << $urandom_range(0, SENSOR_COUNT - 1));
            if ($urandom_range(0, 1) == 1) m |= SENSOR_COUNT'(1 << $urandom_range(0, 7));
          end
          4, 5, 6: begin
            width = $urandom_range(1, SENSOR_COUNT);
            pos = $urandom_range(0, SENSOR_COUNT - width);
            m = SENSOR_COUNT'(((1 << width) - 1) << pos);
          end
          7, 8: m = SENSOR_COUNT'($urandom_range(0, 255));
          default: m = ($urandom_range(0, 1) == 1) ? '1 : '0;
        endcase
        if (jumps && $urandom_range(0, 24) == 0) begin
          now_ms = $urandom;
        end else begin
          now_ms += TimeW'($urandom_range(0, 25));
        end
        push_snap(m, now_ms);
        k++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // register defaults; lone candidates dropped before they can latch
    push_snap(8'h00, 32'h0000_0000);
    push_snap(8'hFF, 32'hFFFF_FFFF);
    push_snap(8'h01, 32'd5);
    push_snap(8'hE0, 32'd6);
    push_snap(8'h80, 32'd7);
    push_snap(8'h00, 32'd8);
    drain();

    // zero threshold, run wider than the sensor row, zero clear maximum
    write_reg(REG_MARKER_COUNT_THRESHOLD, 32'd0);
    write_reg(REG_MARKER_RUN_WIDTH, 32'd9);
    write_reg(REG_CLEAR_MAX_ACTIVE, 32'd0);
    push_snap(8'hFF, 32'd100);
    push_snap(8'h01, 32'd101);
    drain();
    write_reg(REG_MARKER_RUN_WIDTH, 32'd0);
    push_snap(8'h00, 32'd102);
    push_snap(8'h55, 32'd103);
    drain();

    // widest settings, candidate timer just short of the limit across wrap
    write_reg(REG_MARKER_COUNT_THRESHOLD, 32'd8);
    write_reg(REG_MARKER_RUN_WIDTH, 32'd8);
    write_reg(REG_CLEAR_MAX_ACTIVE, 32'd8);
    write_reg(REG_CLEAR_CONFIRM_TIME, 32'hFFFF_FFFF);
    push_snap(8'hFF, 32'd200);
    push_snap(8'hFE, 32'hFFFF_FFFE);
    push_snap(8'h7F, 32'hFFFF_FFFC);
    push_snap(8'h01, 32'h0000_0000);
    push_snap(8'h00, 32'h0000_0001);
    drain();

    // adjacency decides presence
    write_reg(REG_MARKER_COUNT_THRESHOLD, 32'd2);
    write_reg(REG_MARKER_RUN_WIDTH, 32'd3);
    write_reg(REG_CLEAR_MAX_ACTIVE, 32'd1);
    push_snap(8'h05, 32'd300);
    push_snap(8'h1C, 32'd301);
    push_snap(8'h80, 32'd302);
    drain();
    now_ms = 32'd1000;

    // start clear held off by a long confirm time
    write_reg(REG_MARKER_COUNT_THRESHOLD, $urandom_range(1, 8));
    write_reg(REG_MARKER_RUN_WIDTH, $urandom_range(0, 8));
    write_reg(REG_CLEAR_MAX_ACTIVE, $urandom_range(1, 4));
    write_reg(REG_CLEAR_CONFIRM_TIME, 32'd1_000_000 + $urandom_range(0, 1_000_000));
    write_reg(REG_MARKER_MIN_ELAPSED, 32'h8000_0000);
    write_reg(REG_MARKER_CONFIRM_TIME, 32'd0);
    write_reg(REG_RUN_START_TIME, now_ms);
    run_stream(100, 1'b0);
    drain();

    // start clear can latch, marker still blocked by min elapsed
    write_reg(REG_MARKER_COUNT_THRESHOLD, $urandom_range(2, 8));
    write_reg(REG_CLEAR_MAX_ACTIVE, $urandom_range(1, 3));
    write_reg(REG_CLEAR_CONFIRM_TIME, $urandom_range(20, 150));
    write_reg(REG_RUN_START_TIME, now_ms);
    run_stream(120, 1'b0);
    drain();

    // marker confirmation, at once or after persisting
    write_reg(REG_CLEAR_CONFIRM_TIME, $urandom_range(0, 40));
    write_reg(REG_MARKER_MIN_ELAPSED, $urandom_range(0, 500));
    write_reg(REG_MARKER_CONFIRM_TIME,
              ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(30, 200)));
    write_reg(REG_RUN_START_TIME, now_ms - $urandom_range(0, 100));
    run_stream(150, 1'b0);
    drain();

    // anything goes, with timestamp jumps
    write_reg(REG_MARKER_COUNT_THRESHOLD, $urandom_range(0, 15));
    write_reg(REG_MARKER_RUN_WIDTH, $urandom_range(0, 15));
    write_reg(REG_CLEAR_MAX_ACTIVE, $urandom_range(0, 15));
    write_reg(REG_CLEAR_CONFIRM_TIME, pick_time());
    write_reg(REG_MARKER_MIN_ELAPSED, pick_time());
    write_reg(REG_MARKER_CONFIRM_TIME, pick_time());
    write_reg(REG_RUN_START_TIME, pick_time());
    run_stream(130, 1'b1);
    drain();

    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
